[hw/rtl/independent_watchdog_core_macros.svh]
// Assertion macros shared by the watchdog RTL.
`ifndef INDEPENDENT_WATCHDOG_CORE_MACROS_SVH
`define INDEPENDENT_WATCHDOG_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define IWDG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("watchdog assertion failed");
`define IWDG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("watchdog assertion failed");
`else
`define IWDG_ASSERT_IMPL(label, ante, cons)
`define IWDG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/iwdg_pkg.sv]
package iwdg_pkg;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [3:0] OFF_KEY = 4'd0;
    localparam logic [3:0] OFF_PR  = 4'd4;
    localparam logic [3:0] OFF_RLR = 4'd8;
    localparam logic [3:0] OFF_SR  = 4'd12;

    localparam logic [15:0] KEY_RELOAD = 16'hAAAA;
    localparam logic [15:0] KEY_ENABLE = 16'hCCCC;
    localparam logic [15:0] KEY_UNLOCK = 16'h5555;

    localparam logic [2:0] SIZE_BYTE = 3'd1;

    localparam logic [1:0] FLAG_PVU = 2'b01;
    localparam logic [1:0] FLAG_RVU = 2'b10;

    localparam logic [11:0] RELOAD_RESET = 12'hFFF;
    localparam logic [2:0]  PR_MAX       = 3'd6;
    localparam logic [8:0]  BASE_DIV     = 9'd4;

    typedef struct packed {
        mode_t       mode;
        logic [3:0]  offset;
        logic [2:0]  access_bytes;
        logic [31:0] wdata;
    } item_t;

    typedef struct packed {
        logic        enabled;
        logic        restart;
        logic [2:0]  prescale_select;
        logic [11:0] reload_value;
    } ctrl_t;

endpackage

[hw/rtl/iwdg_regfile.sv]
module iwdg_regfile (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  iwdg_pkg::item_t     item,
    output logic [11:0]         rdata,
    output iwdg_pkg::ctrl_t     ctrl
);

    logic [2:0]  prescale_reg;
    logic [2:0]  prescale_next;
    logic [11:0] reload_reg;
    logic [11:0] reload_next;
    logic        enabled_reg;
    logic        enabled_next;
    logic        unlocked_reg;
    logic        unlocked_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [15:0] key;
    logic        is_write;
    logic        is_tick;
    logic        key_write;
    logic        reg_write_ok;

    // A byte access keeps only the low byte, so it can never match a key.
    assign key = (item.access_bytes == iwdg_pkg::SIZE_BYTE) ?
                 {8'h00, item.wdata[7:0]} : item.wdata[15:0];

    assign is_write     = step && (item.mode == iwdg_pkg::MODE_WRITE);
    assign is_tick      = step && (item.mode == iwdg_pkg::MODE_TICK);
    assign key_write    = is_write && (item.offset == iwdg_pkg::OFF_KEY);
    assign reg_write_ok = is_write && unlocked_reg && !enabled_reg;

    always_comb
    begin
        prescale_next = prescale_reg;
        reload_next   = reload_reg;
        enabled_next  = enabled_reg;
        unlocked_next = unlocked_reg;
        status_next   = status_reg;
        if (is_tick)
        begin
            status_next = 2'b00;
        end
        if (key_write && (key == iwdg_pkg::KEY_UNLOCK))
        begin
            unlocked_next = 1'b1;
        end
        if (key_write && (key == iwdg_pkg::KEY_ENABLE))
        begin
            enabled_next  = 1'b1;
            unlocked_next = 1'b0;
        end
        if (reg_write_ok && (item.offset == iwdg_pkg::OFF_PR))
        begin
            prescale_next = item.wdata[2:0];
            status_next   = status_reg | iwdg_pkg::FLAG_PVU;
        end
        if (reg_write_ok && (item.offset == iwdg_pkg::OFF_RLR))
        begin
            reload_next = item.wdata[11:0];
            status_next = status_reg | iwdg_pkg::FLAG_RVU;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= 3'd0;
            reload_reg   <= iwdg_pkg::RELOAD_RESET;
            enabled_reg  <= 1'b0;
            unlocked_reg <= 1'b0;
            status_reg   <= 2'b00;
        end
        else
        begin
            prescale_reg <= prescale_next;
            reload_reg   <= reload_next;
            enabled_reg  <= enabled_next;
            unlocked_reg <= unlocked_next;
            status_reg   <= status_next;
        end
    end

    always_comb
    begin
        rdata = 12'd0;
        if (item.mode == iwdg_pkg::MODE_READ)
        begin
            case (item.offset)
                iwdg_pkg::OFF_PR:  rdata = {9'd0, prescale_reg};
                iwdg_pkg::OFF_RLR: rdata = (item.access_bytes == iwdg_pkg::SIZE_BYTE) ?
                                           {4'd0, reload_reg[7:0]} : reload_reg;
                iwdg_pkg::OFF_SR:  rdata = {10'd0, status_reg};
                default:           rdata = 12'd0;
            endcase
        end
    end

    assign ctrl.enabled         = enabled_reg;
    assign ctrl.restart         = key_write && (((key == iwdg_pkg::KEY_RELOAD) && enabled_reg) ||
                                                (key == iwdg_pkg::KEY_ENABLE));
    assign ctrl.prescale_select = prescale_reg;
    assign ctrl.reload_value    = reload_reg;

endmodule

[hw/rtl/iwdg_counter.sv]
`include "independent_watchdog_core_macros.svh"

module iwdg_counter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick,
    input  iwdg_pkg::ctrl_t ctrl,
    output logic            reset_request
);

    logic [7:0]  div_reg;
    logic [7:0]  div_next;
    logic [11:0] down_reg;
    logic [11:0] down_next;
    logic        counting_reg;
    logic        counting_next;
    logic [2:0]  sel;
    logic [8:0]  period;
    logic [8:0]  div_inc;
    logic        wrap;

    // Prescaler settings above six divide by 256, as six does.
    assign sel     = (ctrl.prescale_select > iwdg_pkg::PR_MAX) ?
                     iwdg_pkg::PR_MAX : ctrl.prescale_select;
    assign period  = iwdg_pkg::BASE_DIV << sel;
    assign div_inc = {1'b0, div_reg} + 9'd1;
    assign wrap    = (div_inc >= period);

    always_comb
    begin
        div_next      = div_reg;
        down_next     = down_reg;
        counting_next = counting_reg;
        reset_request = 1'b0;
        if (ctrl.restart)
        begin
            div_next      = 8'd0;
            down_next     = ctrl.reload_value;
            counting_next = 1'b1;
        end
        else if (tick && counting_reg)
        begin
            if (wrap)
            begin
                div_next = 8'd0;
                if (down_reg == 12'd0)
                begin
                    counting_next = 1'b0;
                    reset_request = 1'b1;
                end
                else
                begin
                    down_next = down_reg - 12'd1;
                end
            end
            else
            begin
                div_next = div_inc[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg      <= 8'd0;
            down_reg     <= 12'd0;
            counting_reg <= 1'b0;
        end
        else
        begin
            div_reg      <= div_next;
            down_reg     <= down_next;
            counting_reg <= counting_next;
        end
    end

    `IWDG_ASSERT_NEXT(a_expiry_stops_count, reset_request, !counting_reg)
    `IWDG_ASSERT_IMPL(a_count_needs_enable, counting_reg, ctrl.enabled)
    `IWDG_ASSERT_IMPL(a_divider_in_period, counting_reg, ({1'b0, div_reg} < period))

endmodule

[hw/rtl/independent_watchdog_core.sv]
// Independent watchdog with a streaming interface. Each input word is a bus
// read, a bus write, one tick of the low-speed clock or no operation, chosen
// by s_tuser, and each gives exactly one output word holding the read data and
// the reset request. The block takes one word per clock cycle with nothing in
// between while the output is not stalled; a word passes an input register and
// then a result register before it is offered on the output. s_tready follows
// m_tready in the same cycle when both registers are full. Key 0x5555 unlocks
// the prescaler and reload registers, key 0xCCCC enables the watchdog and
// starts the countdown, and key 0xAAAA restarts it; expiry comes after
// (reload+1)*(4<<min(pr,6)) ticks, and counting then stops until a restart.
`include "independent_watchdog_core_macros.svh"

module independent_watchdog_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // offset[3:0], access_bytes[6:4], wdata[38:7]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // rdata[11:0], reset_request[12]
);

    logic              in_valid_reg;
    logic              in_valid_next;
    iwdg_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [12:0]       out_data_reg;
    logic              advance;
    logic              in_take;
    logic [11:0]       rdata;
    logic              reset_request;
    logic              tick;
    iwdg_pkg::ctrl_t   ctrl;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign tick     = advance && (in_item_reg.mode == iwdg_pkg::MODE_TICK);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.mode         <= iwdg_pkg::mode_t'(s_tuser);
            in_item_reg.offset       <= s_tdata[3:0];
            in_item_reg.access_bytes <= s_tdata[6:4];
            in_item_reg.wdata        <= s_tdata[38:7];
        end
        if (advance)
        begin
            out_data_reg <= {reset_request, rdata};
        end
    end

    iwdg_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .rdata (rdata),
        .ctrl  (ctrl)
    );

    iwdg_counter u_counter (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick),
        .ctrl          (ctrl),
        .reset_request (reset_request)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

    `IWDG_ASSERT_NEXT(a_held_word_kept, in_valid_reg && !advance,
                      in_valid_reg && $stable(in_item_reg))
    `IWDG_ASSERT_IMPL(a_request_only_on_tick, reset_request, tick)

endmodule
